FILE: rtl/core/m3i_pkg.sv
// m3i_pkg: shared types and constants for the 3x3 matrix inverse core.
// No dependencies; compiled first.
package m3i_pkg;

  localparam int NUM_ELEM = 9;

  // determinant status, carried from the cofactor unit to the lanes
  typedef struct packed {
    logic neg;
    logic zero;
  } m3i_det_t;

  // per-lane status, carried from a divider lane to the merge stage
  typedef struct packed {
    logic neg;   // result sign
    logic ovf;   // quotient too wide for the lane
    logic sing;  // determinant was zero
  } m3i_lane_t;

endpackage

FILE: rtl/core/m3i_if.sv
// m3i_in_if / m3i_out_if: valid/ready channels for matrix words and inverse words.
// No dependencies.
interface m3i_in_if #(parameter int DATA_WIDTH = 32);
  logic                         valid;
  logic                         ready;
  logic signed [DATA_WIDTH-1:0] a_00, a_01, a_02;
  logic signed [DATA_WIDTH-1:0] a_10, a_11, a_12;
  logic signed [DATA_WIDTH-1:0] a_20, a_21, a_22;

  modport source (output valid, a_00, a_01, a_02, a_10, a_11, a_12, a_20, a_21, a_22,
                  input ready);
  modport sink (input valid, a_00, a_01, a_02, a_10, a_11, a_12, a_20, a_21, a_22,
                output ready);
endinterface

interface m3i_out_if #(parameter int DATA_WIDTH = 32);
  logic                         valid;
  logic                         ready;
  logic signed [DATA_WIDTH-1:0] inv_00, inv_01, inv_02;
  logic signed [DATA_WIDTH-1:0] inv_10, inv_11, inv_12;
  logic signed [DATA_WIDTH-1:0] inv_20, inv_21, inv_22;
  logic                         singular;
  logic                         saturated;

  modport source (output valid, inv_00, inv_01, inv_02, inv_10, inv_11, inv_12,
                  inv_20, inv_21, inv_22, singular, saturated, input ready);
  modport sink (input valid, inv_00, inv_01, inv_02, inv_10, inv_11, inv_12,
                inv_20, inv_21, inv_22, singular, saturated, output ready);
endinterface

FILE: rtl/core/m3i_cofactor.sv
// m3i_cofactor: six-stage pipeline forming the adjugate and |det| of a 3x3 matrix.
// Depends on m3i_pkg.
module m3i_cofactor #(
  parameter int DATA_WIDTH = 32
) (
  input  logic                              clk,
  input  logic                              en,
  input  logic signed [DATA_WIDTH-1:0]      a_i [m3i_pkg::NUM_ELEM],
  output logic signed [2*DATA_WIDTH:0]      adj_o [m3i_pkg::NUM_ELEM],
  output logic        [3*DATA_WIDTH+2:0]    dabs_o,
  output m3i_pkg::m3i_det_t                 dinfo_o
);
  import m3i_pkg::*;

  localparam int DW   = DATA_WIDTH;
  localparam int MW   = 2 * DW + 1;
  localparam int PW   = 2 * DW;
  localparam int DETW = 3 * DW + 3;

  // adj[k] = a[P]*a[Q] - a[R]*a[S]  (transposed cofactors)
  localparam int MP [NUM_ELEM] = '{4, 2, 1, 5, 0, 2, 3, 1, 0};
  localparam int MQ [NUM_ELEM] = '{8, 7, 5, 6, 8, 3, 7, 6, 4};
  localparam int MR [NUM_ELEM] = '{5, 1, 2, 3, 2, 0, 4, 0, 1};
  localparam int MS [NUM_ELEM] = '{7, 8, 4, 8, 6, 5, 6, 7, 3};

  logic signed [PW-1:0]   pa_r [NUM_ELEM];
  logic signed [PW-1:0]   pb_r [NUM_ELEM];
  logic signed [DW-1:0]   r0_s1_r [3];
  logic signed [DW-1:0]   r0_s2_r [3];
  logic signed [MW-1:0]   adj_s2_r [NUM_ELEM];
  logic signed [MW-1:0]   adj_s3_r [NUM_ELEM];
  logic signed [MW-1:0]   adj_s4_r [NUM_ELEM];
  logic signed [MW-1:0]   adj_s5_r [NUM_ELEM];
  logic signed [MW-1:0]   adj_s6_r [NUM_ELEM];
  logic signed [MW-1:0]   lo_r [3];
  logic signed [MW-1:0]   hi_r [3];
  logic signed [DETW-1:0] tm_r [3];
  logic signed [DETW-1:0] det_r;
  logic        [DETW-1:0] dabs_r;
  m3i_det_t               dinfo_r;

  logic signed [DETW-1:0] hx [3];
  logic signed [DETW-1:0] lx [3];
  logic signed [MW-1:0]   ma [NUM_ELEM];
  logic signed [MW-1:0]   mb [NUM_ELEM];

  always_comb begin
    for (int j = 0; j < 3; j++) begin
      hx[j] = DETW'(hi_r[j]);
      lx[j] = DETW'(lo_r[j]);
    end
    for (int k = 0; k < NUM_ELEM; k++) begin
      ma[k] = MW'(pa_r[k]);
      mb[k] = MW'(pb_r[k]);
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      // products
      for (int k = 0; k < NUM_ELEM; k++) begin
        pa_r[k] <= PW'(a_i[MP[k]] * a_i[MQ[k]]);
        pb_r[k] <= PW'(a_i[MR[k]] * a_i[MS[k]]);
      end
      for (int j = 0; j < 3; j++) r0_s1_r[j] <= a_i[j];
      // minors
      for (int k = 0; k < NUM_ELEM; k++) adj_s2_r[k] <= ma[k] - mb[k];
      r0_s2_r <= r0_s1_r;
      // det partial products: row 0 against adj[0], adj[3], adj[6]
      for (int j = 0; j < 3; j++) begin
        lo_r[j] <= MW'(r0_s2_r[j] * $signed({1'b0, adj_s2_r[3*j][DW-1:0]}));
        hi_r[j] <= MW'(r0_s2_r[j] * $signed(adj_s2_r[3*j][MW-1:DW]));
      end
      adj_s3_r <= adj_s2_r;
      for (int j = 0; j < 3; j++) tm_r[j] <= (hx[j] <<< DW) + lx[j];
      adj_s4_r <= adj_s3_r;
      det_r    <= tm_r[0] + tm_r[1] + tm_r[2];
      adj_s5_r <= adj_s4_r;
      dabs_r        <= det_r[DETW-1] ? DETW'(-det_r) : DETW'(det_r);
      dinfo_r.neg   <= det_r[DETW-1];
      dinfo_r.zero  <= (det_r == '0);
      adj_s6_r      <= adj_s5_r;
    end
  end

  assign adj_o   = adj_s6_r;
  assign dabs_o  = dabs_r;
  assign dinfo_o = dinfo_r;

endmodule

FILE: rtl/core/m3i_div_lane.sv
// m3i_div_lane: one pipelined restoring divider lane, one quotient bit per stage.
// Depends on m3i_pkg.
module m3i_div_lane #(
  parameter int DATA_WIDTH = 32,
  parameter int FRAC_BITS  = 16
) (
  input  logic                           clk,
  input  logic                           en,
  input  logic signed [2*DATA_WIDTH:0]   cof_i,
  input  logic        [3*DATA_WIDTH+2:0] dabs_i,
  input  m3i_pkg::m3i_det_t              dinfo_i,
  output logic        [DATA_WIDTH:0]     q_o,
  output logic        [3*DATA_WIDTH+2:0] rem_o,
  output logic        [3*DATA_WIDTH+2:0] dabs_o,
  output m3i_pkg::m3i_lane_t             st_o
);
  import m3i_pkg::*;

  localparam int DW   = DATA_WIDTH;
  localparam int MW   = 2 * DW + 1;
  localparam int DETW = 3 * DW + 3;
  localparam int QW   = DW + 1;
  localparam int NW   = MW + 2 * FRAC_BITS;
  localparam int HW   = NW - QW;
  localparam int CW   = (HW > DETW) ? HW : DETW;

  logic [MW-1:0]   cabs;
  logic [NW-1:0]   num;
  logic [CW-1:0]   rhi;
  logic            ovf;

  logic [DETW-1:0] rem_r [QW+1];
  logic [QW-1:0]   nl_r  [QW+1];
  logic [QW-1:0]   q_r   [QW+1];
  logic [DETW-1:0] d_r   [QW+1];
  m3i_lane_t       st_r  [QW+1];

  // numerator |C| * 2^(2F); its top bits seed the remainder
  always_comb begin
    cabs = cof_i[MW-1] ? MW'(-cof_i) : MW'(cof_i);
    num  = {cabs, {(2*FRAC_BITS){1'b0}}};
    rhi  = CW'(num[NW-1:QW]);
    ovf  = (rhi >= CW'(dabs_i));
  end

  always_ff @(posedge clk) begin
    if (en) begin
      rem_r[0]    <= ovf ? '0 : rhi[DETW-1:0];
      nl_r[0]     <= num[QW-1:0];
      q_r[0]      <= '0;
      d_r[0]      <= dabs_i;
      st_r[0].neg  <= cof_i[MW-1] ^ dinfo_i.neg;
      st_r[0].ovf  <= ovf;
      st_r[0].sing <= dinfo_i.zero;
    end
  end

  for (genvar k = 0; k < QW; k++) begin : g_stage
    logic [DETW:0] t;
    logic          ge;
    always_comb begin
      t  = {rem_r[k], nl_r[k][QW-1]};
      ge = (t >= {1'b0, d_r[k]});
    end
    always_ff @(posedge clk) begin
      if (en) begin
        rem_r[k+1] <= ge ? DETW'(t - {1'b0, d_r[k]}) : t[DETW-1:0];
        nl_r[k+1]  <= {nl_r[k][QW-2:0], 1'b0};
        q_r[k+1]   <= {q_r[k][QW-2:0], ge};
        d_r[k+1]   <= d_r[k];
        st_r[k+1]  <= st_r[k];
      end
    end
  end

  assign q_o    = q_r[QW];
  assign rem_o  = rem_r[QW];
  assign dabs_o = d_r[QW];
  assign st_o   = st_r[QW];

endmodule

FILE: rtl/core/m3i_merge.sv
// m3i_merge: rounds, signs and clips the nine lane quotients and merges the flags.
// Depends on m3i_pkg.
module m3i_merge #(
  parameter int DATA_WIDTH = 32
) (
  input  logic        [DATA_WIDTH:0]     q_i    [m3i_pkg::NUM_ELEM],
  input  logic        [3*DATA_WIDTH+2:0] rem_i  [m3i_pkg::NUM_ELEM],
  input  logic        [3*DATA_WIDTH+2:0] dabs_i,
  input  m3i_pkg::m3i_lane_t             st_i   [m3i_pkg::NUM_ELEM],
  output logic signed [DATA_WIDTH-1:0]   inv_o  [m3i_pkg::NUM_ELEM],
  output logic                           singular_o,
  output logic                           saturated_o
);
  import m3i_pkg::*;

  localparam int DW   = DATA_WIDTH;
  localparam int QW   = DW + 1;

  logic [QW:0] mag  [NUM_ELEM];
  logic [QW:0] lim  [NUM_ELEM];
  logic [QW:0] m    [NUM_ELEM];
  logic        clip [NUM_ELEM];
  logic        rup  [NUM_ELEM];

  always_comb begin
    saturated_o = 1'b0;
    singular_o  = st_i[0].sing;
    for (int i = 0; i < NUM_ELEM; i++) begin
      // round half away: bump when 2*rem >= |det|
      rup[i]  = ({rem_i[i], 1'b0} >= {1'b0, dabs_i});
      mag[i]  = {1'b0, q_i[i]} + {{QW{1'b0}}, rup[i]};
      lim[i]  = st_i[i].neg ? ((QW+1)'(1) << (DW-1)) : (((QW+1)'(1) << (DW-1)) - 1'b1);
      clip[i] = st_i[i].ovf || (mag[i] > lim[i]);
      m[i]    = clip[i] ? lim[i] : mag[i];
      if (st_i[0].sing) begin
        inv_o[i] = '0;
      end else begin
        inv_o[i] = st_i[i].neg ? DW'(-m[i]) : DW'(m[i]);
        saturated_o = saturated_o | clip[i];
      end
    end
  end

endmodule

FILE: rtl/core/matrix3x3_inverse_core.sv
// matrix3x3_inverse_core: streaming 3x3 Q-format matrix inverse, top level.
// Depends on m3i_pkg, m3i_if, m3i_cofactor, m3i_div_lane, m3i_merge.
//
// Usage
//   in_ch  : one word per matrix, nine signed elements a_rc, row-major.
//   out_ch : one word per matrix, nine entries inv_rc = adj(A)/det(A),
//            rounded to nearest (ties away from zero), clipped to range,
//            plus singular (det == 0, entries zero) and saturated flags.
//   A word moves when valid and ready are both high.
// Timing
//   Throughput: one word per cycle while out_ch does not stall.
//   Path from acceptance to out_ch.valid: 6 cofactor/determinant stages,
//   one numerator stage, DATA_WIDTH + 1 divider stages (one quotient bit
//   each, nine lanes side by side), and the output register after the merge
//   logic.
// Reset and stall
//   rst_n (synchronous, active low) empties the pipeline and output stages.
//   When out_ch stalls, one more word lands in a skid register, then the
//   whole pipeline freezes and in_ch.ready drops until the skid drains.
module matrix3x3_inverse_core #(
  parameter int DATA_WIDTH = 32,
  parameter int FRAC_BITS  = 16
) (
  input  logic      clk,
  input  logic      rst_n,
  m3i_in_if.sink    in_ch,
  m3i_out_if.source out_ch
);
  import m3i_pkg::*;

  localparam int DW   = DATA_WIDTH;
  localparam int MW   = 2 * DW + 1;
  localparam int DETW = 3 * DW + 3;
  localparam int QW   = DW + 1;
  localparam int PL   = 7 + QW;   // pipeline depth before the output register

  logic              en;
  logic [PL-1:0]     vld_r;
  logic [PL-1:0]     vld_nxt;

  logic signed [DW-1:0]   a      [NUM_ELEM];
  logic signed [MW-1:0]   adj    [NUM_ELEM];
  logic        [DETW-1:0] dabs;
  m3i_det_t               dinfo;

  logic        [QW-1:0]   q      [NUM_ELEM];
  logic        [DETW-1:0] rem    [NUM_ELEM];
  logic        [DETW-1:0] dl     [NUM_ELEM];
  m3i_lane_t              st     [NUM_ELEM];

  logic signed [DW-1:0]   inv    [NUM_ELEM];
  logic                   sing;
  logic                   sat;

  // output register and skid
  logic                   ov_r;
  logic signed [DW-1:0]   inv_r  [NUM_ELEM];
  logic                   sing_r, sat_r;
  logic                   sk_v_r;
  logic signed [DW-1:0]   sk_inv_r [NUM_ELEM];
  logic                   sk_sing_r, sk_sat_r;

  // the pipe only moves while the skid is empty
  assign en          = !sk_v_r;
  assign in_ch.ready = en;

  assign a[0] = in_ch.a_00;
  assign a[1] = in_ch.a_01;
  assign a[2] = in_ch.a_02;
  assign a[3] = in_ch.a_10;
  assign a[4] = in_ch.a_11;
  assign a[5] = in_ch.a_12;
  assign a[6] = in_ch.a_20;
  assign a[7] = in_ch.a_21;
  assign a[8] = in_ch.a_22;

  m3i_cofactor #(.DATA_WIDTH(DW)) u_cof (
    .clk     (clk),
    .en      (en),
    .a_i     (a),
    .adj_o   (adj),
    .dabs_o  (dabs),
    .dinfo_o (dinfo)
  );

  // nine divider lanes, one per adjugate entry
  for (genvar i = 0; i < NUM_ELEM; i++) begin : g_lane
    m3i_div_lane #(.DATA_WIDTH(DW), .FRAC_BITS(FRAC_BITS)) u_lane (
      .clk     (clk),
      .en      (en),
      .cof_i   (adj[i]),
      .dabs_i  (dabs),
      .dinfo_i (dinfo),
      .q_o     (q[i]),
      .rem_o   (rem[i]),
      .dabs_o  (dl[i]),
      .st_o    (st[i])
    );
  end

  m3i_merge #(.DATA_WIDTH(DW)) u_merge (
    .q_i         (q),
    .rem_i       (rem),
    .dabs_i      (dl[0]),
    .st_i        (st),
    .inv_o       (inv),
    .singular_o  (sing),
    .saturated_o (sat)
  );

  assign vld_nxt = {vld_r[PL-2:0], in_ch.valid};

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r  <= '0;
      ov_r   <= 1'b0;
      sk_v_r <= 1'b0;
    end else begin
      if (en) vld_r <= vld_nxt;
      if (out_ch.ready || !ov_r) begin
        if (sk_v_r) begin
          ov_r   <= 1'b1;
          sk_v_r <= 1'b0;
        end else begin
          ov_r   <= vld_r[PL-1];
        end
      end else if (en && vld_r[PL-1]) begin
        sk_v_r <= 1'b1;
      end
    end
  end

  // payload: no reset
  always_ff @(posedge clk) begin
    if (out_ch.ready || !ov_r) begin
      if (sk_v_r) begin
        inv_r  <= sk_inv_r;
        sing_r <= sk_sing_r;
        sat_r  <= sk_sat_r;
      end else begin
        inv_r  <= inv;
        sing_r <= sing;
        sat_r  <= sat;
      end
    end else if (en) begin
      sk_inv_r  <= inv;
      sk_sing_r <= sing;
      sk_sat_r  <= sat;
    end
  end

  assign out_ch.valid     = ov_r;
  assign out_ch.inv_00    = inv_r[0];
  assign out_ch.inv_01    = inv_r[1];
  assign out_ch.inv_02    = inv_r[2];
  assign out_ch.inv_10    = inv_r[3];
  assign out_ch.inv_11    = inv_r[4];
  assign out_ch.inv_12    = inv_r[5];
  assign out_ch.inv_20    = inv_r[6];
  assign out_ch.inv_21    = inv_r[7];
  assign out_ch.inv_22    = inv_r[8];
  assign out_ch.singular  = sing_r;
  assign out_ch.saturated = sat_r;

endmodule

FILE: verif/tb.sv
// tb: self-checking testbench for matrix3x3_inverse_core, with an exact inverse predictor.
// Depends on m3i_pkg, m3i_if and the core RTL.
module tb;
  timeunit 1ns;
  timeprecision 1ps;
  import m3i_pkg::*;

  localparam int DW = 32;
  localparam int FB = 16;
  localparam int LATENCY = DW + 9;
  localparam int CYCLE_LIMIT = 400000;
  localparam int ITEMS_PER_PHASE = 160;

  typedef logic signed [DW-1:0] elem_t;
  typedef logic signed [255:0] wide_t;

  typedef struct {
    elem_t a [NUM_ELEM];
  } matrix_t;

  typedef struct {
    elem_t inv [NUM_ELEM];
    logic  singular;
    logic  saturated;
  } inverse_t;

  // Keeps expected inverses in order and compares each output word with the oldest one.
  class inverse_scoreboard;
    inverse_t pending [$];
    int mismatches = 0;

    // exact cofactor inverse, rounded to nearest with ties away from zero
    function inverse_t invert(matrix_t m);
      inverse_t r;
      wide_t e [NUM_ELEM];
      wide_t adj [NUM_ELEM];
      wide_t det, num;
      logic [255:0] adet, anum, q, lim;
      logic neg;
      for (int i = 0; i < NUM_ELEM; i++) e[i] = m.a[i];
      adj[0] = e[4] * e[8] - e[5] * e[7];
      adj[1] = e[2] * e[7] - e[1] * e[8];
      adj[2] = e[1] * e[5] - e[2] * e[4];
      adj[3] = e[5] * e[6] - e[3] * e[8];
      adj[4] = e[0] * e[8] - e[2] * e[6];
      adj[5] = e[2] * e[3] - e[0] * e[5];
      adj[6] = e[3] * e[7] - e[4] * e[6];
      adj[7] = e[1] * e[6] - e[0] * e[7];
      adj[8] = e[0] * e[4] - e[1] * e[3];
      det = e[0] * adj[0] + e[1] * adj[3] + e[2] * adj[6];
      r.singular = (det == 0);
      r.saturated = 1'b0;
      for (int i = 0; i < NUM_ELEM; i++) r.inv[i] = '0;
      if (r.singular) return r;
      adet = (det < 0) ? -det : det;
      for (int i = 0; i < NUM_ELEM; i++) begin
        num  = adj[i] <<< (2 * FB);
        neg  = (num < 0) != (det < 0);
        anum = (num < 0) ? -num : num;
        q    = (2 * anum + adet) / (2 * adet);
        lim  = neg ? (256'd1 << (DW - 1)) : ((256'd1 << (DW - 1)) - 1);
        if (q > lim) begin
          q = lim;
          r.saturated = 1'b1;
        end
        r.inv[i] = neg ? elem_t'(-q) : elem_t'(q);
      end
      return r;
    endfunction

    function void note_matrix(matrix_t m);
      pending = {pending, invert(m)};
    endfunction

    function void check_inverse(inverse_t got);
      inverse_t want;
      bit bad;
      if (pending.size() == 0) begin
        mismatches++;
        if (mismatches <= 10) $display("ERROR: unexpected output word");
        return;
      end
      want = pending.pop_front();
      bad = (got.singular !== want.singular) || (got.saturated !== want.saturated);
      for (int i = 0; i < NUM_ELEM; i++) if (got.inv[i] !== want.inv[i]) bad = 1;
      if (bad) begin
        mismatches++;
        if (mismatches <= 10) begin
          $display("ERROR: inverse mismatch sing %b/%b sat %b/%b (exp/act)",
                   want.singular, got.singular, want.saturated, got.saturated);
          for (int i = 0; i < NUM_ELEM; i++)
            $display("  inv[%0d] exp %h act %h", i, want.inv[i], got.inv[i]);
        end
      end
    endfunction
  endclass

  logic clk = 1'b0;
  logic rst_n = 1'b0;

  m3i_in_if  #(.DATA_WIDTH(DW)) in_ch ();
  m3i_out_if #(.DATA_WIDTH(DW)) out_ch ();

  matrix3x3_inverse_core #(.DATA_WIDTH(DW), .FRAC_BITS(FB)) DUT (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_ch  (in_ch),
    .out_ch (out_ch)
  );

  inverse_scoreboard sb = new();

  int send_idle_pct = 0;   // chance of a gap before each word
  int recv_stall_pct = 0;  // chance of ready low in a cycle
  int accepted_out = 0;
  int cycles = 0;

  initial begin
    forever #1 clk = ~clk;
  end

  initial begin
    in_ch.valid = 1'b0;
    in_ch.a_00 = '0; in_ch.a_01 = '0; in_ch.a_02 = '0;
    in_ch.a_10 = '0; in_ch.a_11 = '0; in_ch.a_12 = '0;
    in_ch.a_20 = '0; in_ch.a_21 = '0; in_ch.a_22 = '0;
    out_ch.ready = 1'b0;
  end

  // watchdog
  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > CYCLE_LIMIT) begin
      $display("Simulation FAILED");
      $finish;
    end
  end

  // Receiver: checks words on handshake, stalls at random, and once holds
  // off for a long stretch so the pipeline fills and in_ch.ready drops.
  initial begin
    inverse_t got;
    int hold_left;
    bit held_once;
    hold_left = 0;
    held_once = 0;
    @(posedge clk);
    while (!rst_n) @(posedge clk);
    forever begin
      if (out_ch.valid && out_ch.ready) begin
        got.inv[0] = out_ch.inv_00; got.inv[1] = out_ch.inv_01; got.inv[2] = out_ch.inv_02;
        got.inv[3] = out_ch.inv_10; got.inv[4] = out_ch.inv_11; got.inv[5] = out_ch.inv_12;
        got.inv[6] = out_ch.inv_20; got.inv[7] = out_ch.inv_21; got.inv[8] = out_ch.inv_22;
        got.singular = out_ch.singular;
        got.saturated = out_ch.saturated;
        sb.check_inverse(got);
        accepted_out++;
      end
      if (!held_once && accepted_out >= 60) begin
        held_once = 1;
        hold_left = 400;
      end
      if (hold_left > 0) begin
        hold_left--;
        out_ch.ready <= 1'b0;
      end else begin
        out_ch.ready <= ($urandom_range(99) >= recv_stall_pct);
      end
      @(posedge clk);
    end
  end

  // Offer one matrix word and hold it until the core takes it.
  task automatic send_matrix(matrix_t m);
    if ($urandom_range(99) < send_idle_pct) begin
      in_ch.valid <= 1'b0;
      repeat ($urandom_range(1, 4)) @(posedge clk);
    end
    in_ch.valid <= 1'b1;
    in_ch.a_00 <= m.a[0]; in_ch.a_01 <= m.a[1]; in_ch.a_02 <= m.a[2];
    in_ch.a_10 <= m.a[3]; in_ch.a_11 <= m.a[4]; in_ch.a_12 <= m.a[5];
    in_ch.a_20 <= m.a[6]; in_ch.a_21 <= m.a[7]; in_ch.a_22 <= m.a[8];
    do @(posedge clk); while (!in_ch.ready);
    sb.note_matrix(m);
  endtask

  function automatic matrix_t diag_matrix(elem_t d0, elem_t d1, elem_t d2);
    matrix_t m;
    for (int i = 0; i < NUM_ELEM; i++) m.a[i] = '0;
    m.a[0] = d0; m.a[4] = d1; m.a[8] = d2;
    return m;
  endfunction

  function automatic matrix_t fill_matrix(elem_t v);
    matrix_t m;
    for (int i = 0; i < NUM_ELEM; i++) m.a[i] = v;
    return m;
  endfunction

  // Random matrix: mostly well-scaled Q16.16 values, some raw full-range,
  // some built singular, some tiny so the inverse clips.
  function automatic matrix_t random_matrix();
    matrix_t m;
    int kind;
    int r;
    kind = $urandom_range(99);
    for (int i = 0; i < NUM_ELEM; i++) begin
      if (kind < 55)      m.a[i] = elem_t'($urandom_range(32'h7FFFF)) - elem_t'(32'h40000);
      else if (kind < 75) m.a[i] = elem_t'($urandom);
      else if (kind < 90) m.a[i] = elem_t'($urandom_range(32'h3FF)) - elem_t'(32'h200);
      else                m.a[i] = elem_t'($urandom_range(32'hFFFF)) - elem_t'(32'h8000);
    end
    if (kind >= 90) begin
      // singular: one row copies another, or a zero row
      r = $urandom_range(2);
      for (int c = 0; c < 3; c++)
        m.a[3 * r + c] = ($urandom_range(1) == 0) ? '0 : m.a[3 * ((r + 1) % 3) + c];
    end
    return m;
  endfunction

  localparam elem_t ONE  = elem_t'(32'h0001_0000);
  localparam elem_t EMAX = elem_t'(32'h7FFF_FFFF);
  localparam elem_t EMIN = elem_t'(32'h8000_0000);

  initial begin
    matrix_t m;
    int drain;
    repeat (5) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // directed words
    send_matrix(diag_matrix(ONE, ONE, ONE));
    send_matrix(fill_matrix('0));
    send_matrix(fill_matrix(EMAX));
    send_matrix(fill_matrix(EMIN));
    send_matrix(diag_matrix(EMAX, EMAX, EMAX));
    send_matrix(diag_matrix(EMIN, EMIN, EMIN));
    send_matrix(diag_matrix(EMIN, EMAX, EMIN));
    send_matrix(diag_matrix(elem_t'(1), elem_t'(1), elem_t'(1)));   // clips high
    send_matrix(diag_matrix(elem_t'(-1), ONE, ONE));                // clips low
    send_matrix(diag_matrix(-ONE, elem_t'(2) * ONE, elem_t'(3) * ONE));
    send_matrix(diag_matrix(elem_t'(3) * ONE, elem_t'(3) * ONE, elem_t'(3) * ONE));
    send_matrix(diag_matrix(elem_t'(-1), elem_t'(-1), elem_t'(-1)));
    m = diag_matrix(ONE, ONE, '0);
    m.a[2] = ONE; m.a[6] = ONE;                                       // permutation-like
    send_matrix(m);
    m = diag_matrix('0, '0, '0);
    m.a[2] = ONE; m.a[4] = ONE; m.a[6] = ONE;                         // anti-diagonal
    send_matrix(m);
    m = diag_matrix(EMAX, EMIN, EMAX);
    m.a[1] = EMIN; m.a[5] = EMAX; m.a[7] = elem_t'(-1);
    send_matrix(m);
    for (int i = 0; i < NUM_ELEM; i++) m.a[i] = elem_t'((i + 1) * 32'h0001_0000);
    send_matrix(m);                                                   // singular 1..9
    m = diag_matrix(elem_t'(2), elem_t'(2), elem_t'(2));             // clips high
    send_matrix(m);

    for (int phase = 0; phase < 4; phase++) begin
      case (phase)
        0: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
        1: begin send_idle_pct = 50; recv_stall_pct = 0;  end
        2: begin send_idle_pct = 0;  recv_stall_pct = 50; end
        default: begin send_idle_pct = 25; recv_stall_pct = 25; end
      endcase
      for (int n = 0; n < ITEMS_PER_PHASE; n++) send_matrix(random_matrix());
    end
    in_ch.valid <= 1'b0;

    while (sb.pending.size() != 0) @(posedge clk);
    drain = 0;
    while (drain < 4 * LATENCY) begin
      @(posedge clk);
      drain++;
    end

    if (sb.mismatches == 0) begin
      $display("Simulation PASSED");
    end else begin
      $display("Simulation FAILED");
    end
    $finish;
  end

endmodule
